@@ hdl/pbcf_pkg.sv @@
// ----------------------------------------------------------------------------
// pbcf_pkg: shared types and constants of the period break cluster finder
// Result item layout, configuration register codes and fixed field widths.
// ----------------------------------------------------------------------------
package pbcf_pkg;

  localparam int POS_OUT_W = 12;   // width of every position field of a result
  localparam int ROW_W     = 13;   // width of the row_width register
  localparam int GAP_W     = 8;    // width of the merge_gap register
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MERGE_GAP = 2'd1;

  localparam logic [ROW_W-1:0] ROW_WIDTH_RST = 13'd4096;
  localparam logic [GAP_W-1:0] MERGE_GAP_RST = 8'd28;

  typedef struct packed {
    logic [POS_OUT_W-1:0] start;
    logic [POS_OUT_W-1:0] stop;
    logic [POS_OUT_W-1:0] center;
    logic                 done;
  } cluster_t;

  // Up to two results per item: a cluster closed by a long gap, then the
  // final cluster of the row.
  typedef struct packed {
    logic     v0;
    cluster_t c0;
    logic     v1;
    cluster_t c1;
  } cluster_pair_t;

endpackage

@@ hdl/pbcf_cell.sv @@
// ----------------------------------------------------------------------------
// pbcf_cell: one stage of the cell delay line
// Holds one cell value and hands it to the next stage on every accepted item.
// ----------------------------------------------------------------------------
module pbcf_cell (
  input  logic clk,
  input  logic rst,
  input  logic shift,
  input  logic clear,
  input  logic d,
  output logic q
);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      q <= 1'b0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

@@ hdl/pbcf_merge.sv @@
// ----------------------------------------------------------------------------
// pbcf_merge: break decision and cluster merging
// Decides the cell PERIOD places behind the input and builds clusters.
// ----------------------------------------------------------------------------
module pbcf_merge #(
  parameter int MAX_WIDTH = 4096,
  parameter int PERIOD    = 14
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  logic                            center_bit,
  input  logic                            left_bit,
  input  logic                            right_bit,
  input  logic [pbcf_pkg::ROW_W-1:0]      row_width,
  input  logic [pbcf_pkg::GAP_W-1:0]      merge_gap,
  output pbcf_pkg::cluster_pair_t         results,
  output logic                            row_end
);

  localparam int PW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int CW = (WW > pbcf_pkg::ROW_W) ? WW : pbcf_pkg::ROW_W;
  localparam int GW = pbcf_pkg::GAP_W + 1;

  logic [PW-1:0] pos, pos_next;
  logic [PW-1:0] open_start, open_start_next;
  logic [PW-1:0] last_break, last_break_next;
  logic          in_cluster, in_cluster_next;
  logic [GW-1:0] gap, gap_next;

  logic [CW-1:0] rw_ext;
  logic [CW-1:0] eff_width;
  logic [CW:0]   pos_x;
  logic          dec_valid;
  logic          brk;
  logic [PW-1:0] dec_pos;
  logic [GW-1:0] gap_inc;
  logic [PW-1:0] first_open;

  function automatic pbcf_pkg::cluster_t make_cluster(input logic [PW-1:0] s,
                                                      input logic [PW-1:0] e,
                                                      input logic done);
    pbcf_pkg::cluster_t r;
    logic [PW:0] sum;
    sum      = {1'b0, s} + {1'b0, e};
    r.start  = pbcf_pkg::POS_OUT_W'(s);
    r.stop   = pbcf_pkg::POS_OUT_W'(e);
    r.center = pbcf_pkg::POS_OUT_W'(sum >> 1);
    r.done   = done;
    return r;
  endfunction

  always_comb begin
    rw_ext = CW'(row_width);
    if (rw_ext == '0) begin
      eff_width = CW'(1);
    end else if (rw_ext > CW'(MAX_WIDTH)) begin
      eff_width = CW'(MAX_WIDTH);
    end else begin
      eff_width = rw_ext;
    end
  end

  always_comb begin
    pos_x     = (CW + 1)'(pos);
    dec_valid = pos_x >= (CW + 1)'(PERIOD);
    dec_pos   = pos - PW'(PERIOD);
    brk       = (pos_x < (CW + 1)'(2 * PERIOD)) || (pos_x >= {1'b0, eff_width})
              || (center_bit != left_bit) || (center_bit != right_bit);
    gap_inc   = gap + GW'(1);
    first_open = dec_valid ? dec_pos + PW'(1) : '0;

    pos_next        = pos;
    open_start_next = open_start;
    last_break_next = last_break;
    in_cluster_next = in_cluster;
    gap_next        = gap;
    results         = '0;
    row_end         = 1'b0;

    if (accept) begin
      if (dec_valid) begin
        if (brk) begin
          if (!in_cluster) begin
            open_start_next = dec_pos;
            in_cluster_next = 1'b1;
          end
          last_break_next = dec_pos;
          gap_next        = '0;
        end else if (in_cluster) begin
          gap_next = gap_inc;
          if (gap_inc > GW'(merge_gap)) begin
            results.v0      = 1'b1;
            results.c0      = make_cluster(open_start, last_break, 1'b0);
            in_cluster_next = 1'b0;
            gap_next        = '0;
          end
        end
      end

      if (pos_x + (CW + 1)'(1) >= {1'b0, eff_width}) begin
        // last cell of the row: emit the final cluster and start over
        results.v1 = 1'b1;
        results.c1 = make_cluster(in_cluster_next ? open_start_next : first_open,
                                  pos, 1'b1);
        row_end         = 1'b1;
        pos_next        = '0;
        open_start_next = '0;
        last_break_next = '0;
        in_cluster_next = 1'b0;
        gap_next        = '0;
      end else begin
        pos_next = pos + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      open_start <= '0;
      last_break <= '0;
      in_cluster <= 1'b0;
      gap        <= '0;
    end else begin
      pos        <= pos_next;
      open_start <= open_start_next;
      last_break <= last_break_next;
      in_cluster <= in_cluster_next;
      gap        <= gap_next;
    end
  end

  a_gap_idle: assert property (@(posedge clk) disable iff (rst)
    !in_cluster |-> gap == '0)
    else $error("gap count nonzero outside a cluster");

  a_row_restart: assert property (@(posedge clk) disable iff (rst)
    row_end |=> (pos == '0) && !in_cluster)
    else $error("row did not restart after its last cell");

endmodule

@@ hdl/pbcf_outq.sv @@
// ----------------------------------------------------------------------------
// pbcf_outq: result queue
// Four-entry queue that takes up to two results per cycle and sends one.
// ----------------------------------------------------------------------------
module pbcf_outq (
  input  logic                    clk,
  input  logic                    rst,
  input  pbcf_pkg::cluster_pair_t push,
  input  logic                    pop,
  output pbcf_pkg::cluster_t      head,
  output logic                    not_empty,
  output logic                    full_for_pair
);

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  pbcf_pkg::cluster_t entries [DEPTH];
  logic [AW-1:0] rd_ptr, wr_ptr, wr_ptr_next, wr_ptr_1;
  logic [AW:0]   count, count_next;

  always_comb begin
    wr_ptr_1    = wr_ptr + AW'(push.v0);
    wr_ptr_next = wr_ptr_1 + AW'(push.v1);
    count_next  = count + (AW + 1)'(push.v0) + (AW + 1)'(push.v1) - (AW + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.v0) begin
      entries[wr_ptr] <= push.c0;
    end
    if (push.v1) begin
      entries[wr_ptr_1] <= push.c1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
    end
  end

  assign head          = entries[rd_ptr];
  assign not_empty     = count != '0;
  assign full_for_pair = count > (AW + 1)'(DEPTH - 2);

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (AW + 1)'(DEPTH))
    else $error("result queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("result queue popped while empty");

endmodule

@@ hdl/period_break_cluster_finder.sv @@
// ----------------------------------------------------------------------------
// period_break_cluster_finder: clusters of period breaks in a binary row
// Marks cells that differ from the cell PERIOD places away and merges them
// into clusters reported with start, end and center.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one cell per item, row after
//   row; row_width cells make a row. Output channel (out_valid / out_stall)
//   carries one cluster per item; row_done marks the last cluster of a row.
//   Configuration: cfg_valid / cfg_ready write register cfg_index
//   (0 = row_width, 1 = merge_gap) with cfg_data; cfg_ready is always high.
// Throughput: one cell per cycle while in_stall is low. The break decision
//   runs PERIOD cells behind the input, taken from a chain of 2*PERIOD delay
//   cells; a cluster enters the result queue when its closing cell is accepted.
//   The row's last cell can close two clusters; the four-entry result queue
//   drains them one per cycle while out_stall is low, and raises in_stall
//   while fewer than two entries are free.
// Reset: rst clears the delay line, the row position, the cluster state and
//   the result queue, and loads row_width = 4096, merge_gap = 28.
// Stall: while out_stall is high the head result holds; the queue keeps
//   taking cells until it cannot absorb a full pair of results.
// ----------------------------------------------------------------------------
module period_break_cluster_finder #(
  parameter int MAX_WIDTH = 4096,
  parameter int PERIOD    = 14
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               cell_req,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [pbcf_pkg::POS_OUT_W-1:0]     span_start,
  output logic [pbcf_pkg::POS_OUT_W-1:0]     span_end,
  output logic [pbcf_pkg::POS_OUT_W-1:0]     cluster_center,
  output logic                               row_done,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pbcf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pbcf_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int TAPS = 2 * PERIOD;

  logic [pbcf_pkg::ROW_W-1:0] row_width;
  logic [pbcf_pkg::GAP_W-1:0] merge_gap;

  logic                    accept;
  logic                    row_end;
  logic [TAPS-1:0]         taps;
  pbcf_pkg::cluster_pair_t results;
  pbcf_pkg::cluster_t      head;
  logic                    full_for_pair;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign in_stall  = full_for_pair;

  // Configuration registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= pbcf_pkg::ROW_WIDTH_RST;
      merge_gap <= pbcf_pkg::MERGE_GAP_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pbcf_pkg::CFG_ROW_WIDTH: row_width <= cfg_data;
        pbcf_pkg::CFG_MERGE_GAP: merge_gap <= cfg_data[pbcf_pkg::GAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Delay line: cell i holds the value seen i+1 items ago. Advance on each
  // accepted cell, clear at the end of a row.
  genvar gi;
  generate
    for (gi = 0; gi < TAPS; gi++) begin : g_cell
      pbcf_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (accept),
        .clear (row_end),
        .d     ((gi == 0) ? cell_req : taps[(gi == 0) ? 0 : gi - 1]),
        .q     (taps[gi])
      );
    end
  endgenerate

  // The decided cell sits PERIOD places behind the new one; its left
  // neighbor at distance PERIOD is the oldest tap, its right one the input.
  pbcf_merge #(
    .MAX_WIDTH (MAX_WIDTH),
    .PERIOD    (PERIOD)
  ) u_merge (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .center_bit (taps[PERIOD-1]),
    .left_bit   (taps[TAPS-1]),
    .right_bit  (cell_req),
    .row_width  (row_width),
    .merge_gap  (merge_gap),
    .results    (results),
    .row_end    (row_end)
  );

  pbcf_outq u_outq (
    .clk           (clk),
    .rst           (rst),
    .push          (results),
    .pop           (out_valid && !out_stall),
    .head          (head),
    .not_empty     (out_valid),
    .full_for_pair (full_for_pair)
  );

  assign span_start     = head.start;
  assign span_end       = head.stop;
  assign cluster_center = head.center;
  assign row_done       = head.done;

  a_no_push_on_idle: assert property (@(posedge clk) disable iff (rst)
    !accept |-> !results.v0 && !results.v1)
    else $error("result produced without an accepted cell");

  a_clear_on_end: assert property (@(posedge clk) disable iff (rst)
    row_end |=> taps == '0)
    else $error("delay line not cleared at row end");

endmodule

@@ tb/period_break_cluster_finder_tb.sv @@
// ----------------------------------------------------------------------------
// period_break_cluster_finder_tb: self-checking bench of the break cluster finder
// Streams rows of cells through the finder, mostly rows that repeat with the
// break period and carry a few flipped cells, with some noise rows mixed in.
// A model of the break decision and of the cluster merging runs in step with
// every accepted cell. Each cluster that comes out is compared field by field
// with the oldest predicted one. Both channels idle at random, and the row
// width and the merge gap move through several settings between phases.
// ----------------------------------------------------------------------------
module period_break_cluster_finder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PERIOD        = 14;
  localparam int MAX_CELLS     = 4096;
  localparam int LINE_LEN      = 2 * PERIOD + 1;
  localparam int RESET_CYCLES  = 11;
  localparam int SETTLE_CYCLES = 6;
  localparam int RANDOM_ITEMS  = 1050;
  localparam int LONG_ROW_CELLS = 200;
  localparam int CYCLE_LIMIT   = 2000000;

  // Register indexes that the finder does not decode: writes to them are ignored.
  localparam logic [pbcf_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [pbcf_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef enum logic {STEP_CFG, STEP_CELL} step_kind_t;

  // One row of the directed table: a register write or one cell. When
  // typed is set, want holds the single cluster that the cell must produce.
  typedef struct {
    step_kind_t                      kind;
    logic [pbcf_pkg::CFG_IDX_W-1:0]  idx;
    logic [pbcf_pkg::CFG_DATA_W-1:0] data;
    logic                            cell_val;
    bit                              typed;
    pbcf_pkg::cluster_t              want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                            in_valid  = 1'b0;
  logic                            cell_req  = 1'b0;
  logic                            out_stall = 1'b0;
  logic                            cfg_valid = 1'b0;
  logic [pbcf_pkg::CFG_IDX_W-1:0]  cfg_index = pbcf_pkg::CFG_ROW_WIDTH;
  logic [pbcf_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  logic                           in_stall;
  logic                           out_valid;
  logic                           cfg_ready;
  logic [pbcf_pkg::POS_OUT_W-1:0] span_start;
  logic [pbcf_pkg::POS_OUT_W-1:0] span_end;
  logic [pbcf_pkg::POS_OUT_W-1:0] cluster_center;
  logic                           row_done;

  period_break_cluster_finder u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .cell_req       (cell_req),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .span_start     (span_start),
    .span_end       (span_end),
    .cluster_center (cluster_center),
    .row_done       (row_done),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Cluster predictor: its own copy of registers, delay line and cluster state
  // --------------------------------------------------------------------------
  logic [pbcf_pkg::ROW_W-1:0] width_reg;
  logic [pbcf_pkg::GAP_W-1:0] gap_limit;
  logic [LINE_LEN-1:0] cell_line;      // bit 0 holds the newest cell
  int unsigned         row_pos;
  bit                  seg_open;
  int unsigned         seg_start;
  int unsigned         seg_last;
  int unsigned         gap_run;

  pbcf_pkg::cluster_t fresh_clusters[$];     // clusters caused by the current cell
  pbcf_pkg::cluster_t expected_clusters[$];  // clusters still owed by the finder

  int errors       = 0;
  int cells_sent   = 0;
  int reg_writes   = 0;
  int clusters_got = 0;
  int rows_got     = 0;
  int cycles       = 0;

  function automatic void clear_row_state();
    cell_line = '0;
    row_pos   = 0;
    seg_open  = 1'b0;
    seg_start = 0;
    seg_last  = 0;
    gap_run   = 0;
  endfunction

  function automatic void close_cluster(int unsigned s, int unsigned e, logic done);
    pbcf_pkg::cluster_t c;
    int unsigned        mid;
    mid      = (s + e) >> 1;
    c.start  = s[pbcf_pkg::POS_OUT_W-1:0];
    c.stop   = e[pbcf_pkg::POS_OUT_W-1:0];
    c.center = mid[pbcf_pkg::POS_OUT_W-1:0];
    c.done   = done;
    fresh_clusters = {fresh_clusters, c};
  endfunction

  // Advance the predictor by one cell; the clusters it closes land in
  // fresh_clusters, a gap-closed one first, then the row's last one.
  function automatic void step_predictor(logic v);
    int unsigned w;
    int unsigned p;
    int unsigned d;
    int unsigned first;
    bit          brk;
    w = width_reg;
    if (w == 0) w = 1;
    if (w > MAX_CELLS) w = MAX_CELLS;
    p = row_pos;
    cell_line = {cell_line[LINE_LEN-2:0], v};

    // The decision for cell d = p - PERIOD: both edges of the row are
    // breaks, otherwise compare against the cells PERIOD away on each side.
    if (p >= PERIOD) begin
      d = p - PERIOD;
      brk = (d < PERIOD) || (d + PERIOD >= w)
         || (cell_line[PERIOD] != cell_line[2*PERIOD])
         || (cell_line[PERIOD] != cell_line[0]);
      if (brk) begin
        if (!seg_open) begin
          seg_start = d;
          seg_open  = 1'b1;
        end
        seg_last = d;
        gap_run  = 0;
      end else if (seg_open) begin
        gap_run++;
        if (gap_run > gap_limit) begin
          close_cluster(seg_start, seg_last, 1'b0);
          seg_open = 1'b0;
          gap_run  = 0;
        end
      end
    end

    // Row end, also when the width shrank under the current position: all
    // undecided cells up to p are breaks and close the last cluster.
    if (p + 1 >= w) begin
      first = (p >= PERIOD) ? p - PERIOD + 1 : 0;
      if (!seg_open) seg_start = first;
      close_cluster(seg_start, p, 1'b1);
      clear_row_state();
    end else begin
      row_pos = p + 1;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch %s: got %0d, want %0d", $realtime, what, got, want);
    errors++;
  endtask

  task automatic check_cluster();
    pbcf_pkg::cluster_t want;
    if (expected_clusters.size() == 0) begin
      report_mismatch("unexpected cluster, start", span_start, -1);
    end else begin
      want = expected_clusters.pop_front();
      if (span_start !== want.start)
        report_mismatch("span_start", span_start, want.start);
      if (span_end !== want.stop)
        report_mismatch("span_end", span_end, want.stop);
      if (cluster_center !== want.center)
        report_mismatch("cluster_center", cluster_center, want.center);
      if (row_done !== want.done)
        report_mismatch("row_done", row_done, want.done);
    end
    clusters_got++;
    if (row_done === 1'b1) rows_got++;
  endtask

  // Take a cluster at every edge where the finder offers one and we do not stall.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) check_cluster();
  end

  // Watchdog: the slowest legal run stays far below this.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d clusters still owed",
               cycles, expected_clusters.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver back-pressure: mostly short stalls, a few long ones, and now and
  // then a long calm stretch with no stall at all.
  // --------------------------------------------------------------------------
  int stall_left = 0;
  int calm_left  = 0;

  always @(negedge clk) begin
    int r;
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (calm_left != 0) begin
      out_stall <= 1'b0;
      calm_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 55)      calm_left  = $urandom_range(1, 8);
      else if (r < 88) stall_left = $urandom_range(1, 3);
      else if (r < 97) stall_left = $urandom_range(4, 20);
      else             calm_left  = $urandom_range(50, 300);
      out_stall <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  bit          no_gaps   = 1'b0;      // stretch with valid held high
  bit          noise_row = 1'b0;      // cells drawn at random
  logic [PERIOD-1:0] motif = '0;      // repeating pattern of periodic rows
  int unsigned flip_den  = 20;        // roughly one flipped cell in flip_den

  function automatic int unsigned pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 99) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic next_cell();
    if (noise_row) return 1'($urandom_range(0, 1));
    return motif[row_pos % PERIOD] ^ ($urandom_range(0, flip_den - 1) == 0);
  endfunction

  // Offer one cell; called at a falling edge, returns at a falling edge with
  // valid still high so that back-to-back items keep it up.
  task automatic send_cell(input logic v, input bit typed,
                           input pbcf_pkg::cluster_t want);
    int unsigned idle;
    idle = pick_gap();
    if (idle != 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    in_valid <= 1'b1;
    cell_req <= v;
    do @(posedge clk); while (in_stall);
    fresh_clusters.delete();
    step_predictor(v);
    if (typed) expected_clusters = {expected_clusters, want};
    else expected_clusters = {expected_clusters, fresh_clusters};
    cells_sent++;
    @(negedge clk);
  endtask

  // Hold off the sender until every owed cluster has come out and the
  // pipeline has had time to settle.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_clusters.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [pbcf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pbcf_pkg::CFG_DATA_W-1:0] data);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      pbcf_pkg::CFG_ROW_WIDTH: width_reg = data[pbcf_pkg::ROW_W-1:0];
      pbcf_pkg::CFG_MERGE_GAP: gap_limit = data[pbcf_pkg::GAP_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Directed table
  // --------------------------------------------------------------------------
  plan_row_t directed_plan[$];

  function automatic void plan_cfg(logic [pbcf_pkg::CFG_IDX_W-1:0] idx,
                                   logic [pbcf_pkg::CFG_DATA_W-1:0] data);
    plan_row_t row;
    row = '{kind: STEP_CFG, idx: idx, data: data, cell_val: 1'b0, typed: 1'b0,
            want: '0};
    directed_plan = {directed_plan, row};
  endfunction

  function automatic void plan_cell(logic v);
    plan_row_t row;
    row = '{kind: STEP_CELL, idx: pbcf_pkg::CFG_ROW_WIDTH, data: '0, cell_val: v,
            typed: 1'b0, want: '0};
    directed_plan = {directed_plan, row};
  endfunction

  function automatic void plan_want(logic v, int s, int e, int c, logic d);
    plan_row_t          row;
    pbcf_pkg::cluster_t want;
    want.start  = pbcf_pkg::POS_OUT_W'(s);
    want.stop   = pbcf_pkg::POS_OUT_W'(e);
    want.center = pbcf_pkg::POS_OUT_W'(c);
    want.done   = d;
    row = '{kind: STEP_CELL, idx: pbcf_pkg::CFG_ROW_WIDTH, data: '0, cell_val: v,
            typed: 1'b1, want: want};
    directed_plan = {directed_plan, row};
  endfunction

  function automatic void build_directed_plan();
    // Width zero acts as one: every cell is a row of its own.
    plan_cfg(pbcf_pkg::CFG_ROW_WIDTH, 13'd0);
    plan_cfg(pbcf_pkg::CFG_MERGE_GAP, 13'd255);
    plan_want(1'b1, 0, 0, 0, 1'b1);
    plan_want(1'b0, 0, 0, 0, 1'b1);
    plan_cfg(pbcf_pkg::CFG_ROW_WIDTH, 13'd1);
    plan_want(1'b1, 0, 0, 0, 1'b1);
    // Two cells per row, no decision is ever taken.
    plan_cfg(pbcf_pkg::CFG_ROW_WIDTH, 13'd2);
    plan_cell(1'b0);
    plan_want(1'b1, 0, 1, 0, 1'b1);
    // Shortest row that takes a decision: one leading break, then the tail.
    plan_cfg(pbcf_pkg::CFG_MERGE_GAP, 13'd0);
    plan_cfg(pbcf_pkg::CFG_ROW_WIDTH, 13'd15);
    for (int i = 0; i < 14; i++) plan_cell(1'(i % 3 == 0));
    plan_want(1'b1, 0, 14, 7, 1'b1);
    // Shrink the row under the current position: the next cell ends it.
    plan_cfg(pbcf_pkg::CFG_ROW_WIDTH, 13'd20);
    for (int i = 0; i < 6; i++) plan_cell(1'(i & 1));
    plan_cfg(pbcf_pkg::CFG_ROW_WIDTH, 13'd5);
    plan_want(1'b1, 0, 6, 3, 1'b1);
    // Undecoded indexes must leave both registers alone.
    plan_cfg(CFG_SPARE_A, 13'h1FFF);
    plan_cfg(CFG_SPARE_B, 13'h0000);
    plan_cell(1'b0);
    plan_cell(1'b1);
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int                 random_cells;
    int                 r;
    int unsigned        width_pick;
    int unsigned        gap_pick;
    int unsigned        phase_cells;
    pbcf_pkg::cluster_t none;

    none = '0;
    width_reg = pbcf_pkg::ROW_WIDTH_RST;
    gap_limit = pbcf_pkg::MERGE_GAP_RST;
    clear_row_state();

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Walk the directed table.
    build_directed_plan();
    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == STEP_CFG)
        write_reg(directed_plan[i].idx, directed_plan[i].data);
      else
        send_cell(directed_plan[i].cell_val, directed_plan[i].typed,
                  directed_plan[i].want);
    end

    // Random phases: new settings, then a run of cells that need not end on
    // a row boundary, so widths also change in the middle of a row.
    random_cells = 0;
    while (random_cells < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 65)      width_pick = $urandom_range(15, 70);
      else if (r < 77) width_pick = $urandom_range(1, 14);
      else if (r < 82) width_pick = 0;
      else if (r < 88) width_pick = LINE_LEN;
      else             width_pick = $urandom_range(71, 200);

      r = $urandom_range(0, 99);
      if (r < 15)      gap_pick = 0;
      else if (r < 25) gap_pick = 255;
      else             gap_pick = $urandom_range(0, 40);
      // Upper data bits do not reach the 8-bit gap register; stir them.
      gap_pick = gap_pick | ($urandom_range(0, 31) << pbcf_pkg::GAP_W);

      if ($urandom_range(0, 1) != 0) begin
        write_reg(pbcf_pkg::CFG_ROW_WIDTH, pbcf_pkg::CFG_DATA_W'(width_pick));
        write_reg(pbcf_pkg::CFG_MERGE_GAP, pbcf_pkg::CFG_DATA_W'(gap_pick));
      end else begin
        write_reg(pbcf_pkg::CFG_MERGE_GAP, pbcf_pkg::CFG_DATA_W'(gap_pick));
        write_reg(pbcf_pkg::CFG_ROW_WIDTH, pbcf_pkg::CFG_DATA_W'(width_pick));
      end
      if ($urandom_range(0, 9) == 0)
        write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                  pbcf_pkg::CFG_DATA_W'($urandom_range(0, 8191)));

      noise_row = ($urandom_range(0, 4) == 0);
      no_gaps   = ($urandom_range(0, 3) == 0);
      motif     = PERIOD'($urandom_range(0, (1 << PERIOD) - 1));
      flip_den  = $urandom_range(8, 60);
      phase_cells = $urandom_range(10, 3 * (width_pick == 0 ? 1 : width_pick) + 10);
      if (phase_cells > 250) phase_cells = 250;

      repeat (phase_cells) send_cell(next_cell(), 1'b0, none);
      random_cells += phase_cells;
    end

    // A long row under an oversized width, which acts as the largest one;
    // then shrink the width so that the next cell ends the row.
    write_reg(pbcf_pkg::CFG_ROW_WIDTH, 13'h1FFF);
    write_reg(pbcf_pkg::CFG_MERGE_GAP, pbcf_pkg::CFG_DATA_W'($urandom_range(0, 255)));
    noise_row = 1'b0;
    no_gaps   = 1'b0;
    motif     = PERIOD'($urandom_range(0, (1 << PERIOD) - 1));
    flip_den  = 150;
    phase_cells = LONG_ROW_CELLS;
    repeat (phase_cells) send_cell(next_cell(), 1'b0, none);
    write_reg(pbcf_pkg::CFG_ROW_WIDTH, 13'd1);
    send_cell(next_cell(), 1'b0, none);

    // Drain: nothing more goes in, wait for every owed cluster.
    in_valid <= 1'b0;
    while (expected_clusters.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run summary: %0d cells, %0d register writes, %0d clusters over %0d rows",
             cells_sent, reg_writes, clusters_got, rows_got);
    $display("Run summary: %0d mismatches found", errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
